/* src/srctl_pkg.sv */
// ----------------------------------------------------------------------------
// srctl_pkg: shared types and constants for the stepper ramp controller
// Payload words, controller/datapath command and status, codes and tables.
// ----------------------------------------------------------------------------
package srctl_pkg;

    // default width of the remaining-step counter
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // function codes of a command word
    localparam logic [1:0] FUNC_MOVE = 2'd0;
    localparam logic [1:0] FUNC_STOP = 2'd1;
    localparam logic [1:0] FUNC_STEP = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE     = 2'd2;

    // configuration reset values
    localparam logic [9:0]  START_SPEED_RST   = 10'd38;
    localparam logic [15:0] STEPS_PER_REV_RST = 16'd4096;
    localparam logic [23:0] TICK_RATE_RST     = 24'd1000000;

    localparam logic [15:0] MAX16        = 16'hFFFF;
    localparam logic [15:0] RAMP_DIV     = 16'd100;
    localparam logic [15:0] SECS_PER_MIN = 16'd60;

    // reciprocals for the constant divides, exact over the full input range:
    // x/60 = ((x >> 2) * TS_RECIP) >> 27, x/100 = (x * RAMP_RECIP) >> 23
    localparam logic [23:0] TS_RECIP   = 24'd8947849;
    localparam logic [16:0] RAMP_RECIP = 17'd83887;

    // shared divider geometry
    localparam int unsigned DIV_NUM_W = 24;
    localparam int unsigned DIV_DEN_W = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

    // which quotient the shared divider is working on
    localparam logic DIV_DECEL = 1'b0;
    localparam logic DIV_INTV  = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] move_steps;
        logic [7:0]         target_rpm;
        logic [15:0]        accel_rate;
    } t_cmd_payload;

    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] interval;
        logic        busy_res;
        logic [31:0] steps_left;
        logic        finished;
    } t_res_payload;

    typedef struct packed {
        logic       load_in;
        logic       stop_do;
        logic       rate_upd;
        logic       move_cnt;
        logic       move_begin;
        logic       step_upd;
        logic       div_start;
        logic       div_store;
        logic       div_sel;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       moving;
        logic       move_zero;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

    // half-step coil patterns, bit3 is coil A
    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0: pat = 4'h8;
            3'd1: pat = 4'hC;
            3'd2: pat = 4'h4;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h2;
            3'd5: pat = 4'h3;
            3'd6: pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

/* src/srctl_stream_if.sv */
// ----------------------------------------------------------------------------
// srctl_stream_if: valid/ready channel
// Carries one payload word per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface srctl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/stepper_ramp_controller.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_controller: half-step stepper driver with trapezoidal ramp
// Takes move, stop and step-event words and returns one result word each.
// ----------------------------------------------------------------------------
// One word at a time. A stop, an idle step event, an unused code or a zero-count move
// needs no pass of the shared radix-2 divider; a step event (step interval) or a move
// while moving (decel point) needs one, and a move that starts a motion needs both.
// A finished result waits in the output register while the next word enters.
// Reset (synchronous, active low) loads register defaults and clears the control and
// motion state; the command, product, result and divider data registers are not reset.
module stepper_ramp_controller #(
    parameter int unsigned COUNT_WIDTH = srctl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srctl_stream_if.sink                      i_cmd,
    srctl_stream_if.source                    o_res,
    input  logic                              i_cfg_we,
    input  logic [srctl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srctl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    srctl_pkg::t_dp_cmd      w_ctl;
    srctl_pkg::t_dp_stat     w_stat;
    srctl_pkg::t_res_payload w_res;
    logic                    w_in_ready;
    logic                    w_res_valid;

    srctl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_ctl)
    );

    srctl_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_payload   (i_cmd.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign i_cmd.ready   = w_in_ready;
    assign o_res.valid   = w_res_valid;
    assign o_res.payload = w_res;
endmodule

/* src/srctl_div.sv */
// ----------------------------------------------------------------------------
// srctl_div: radix-2 restoring divider
// One quotient bit per cycle; a zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module srctl_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [srctl_pkg::DIV_NUM_W-1:0]  i_dividend,
    input  logic [srctl_pkg::DIV_DEN_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [srctl_pkg::DIV_NUM_W-1:0]  o_quot
);
    localparam int unsigned NW = srctl_pkg::DIV_NUM_W;
    localparam int unsigned DW = srctl_pkg::DIV_DEN_W;
    localparam int unsigned CW = srctl_pkg::DIV_CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_fit;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_fit  = w_sh >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // dividend bits shift out at the top, quotient bits in at the bottom
            n_rem = w_fit ? w_diff[DW-1:0] : w_sh[DW-1:0];
            n_quo = {r_quo[NW-2:0], w_fit};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

/* src/srctl_datapath.sv */
// ----------------------------------------------------------------------------
// srctl_datapath: motion state, configuration and result register
// Applies controller commands to the ramp state and owns the shared divider.
// ----------------------------------------------------------------------------
module srctl_datapath #(
    parameter int unsigned COUNT_WIDTH = srctl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srctl_pkg::t_cmd_payload           i_payload,
    input  logic                              i_cfg_we,
    input  logic [srctl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srctl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  srctl_pkg::t_dp_cmd                i_ctl,
    output srctl_pkg::t_dp_stat               o_stat,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output srctl_pkg::t_res_payload           o_res
);
    localparam int unsigned CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = '1;
    localparam int unsigned NW = srctl_pkg::DIV_NUM_W;
    localparam int unsigned DW = srctl_pkg::DIV_DEN_W;

    // configuration
    logic [9:0]  r_start_speed;
    logic [15:0] r_spr;
    logic [23:0] r_tick;

    // motion state
    srctl_pkg::t_cmd_payload r_in, n_in;
    logic [23:0]   r_prod, n_prod;
    logic [CW-1:0] r_steps, n_steps;
    logic [15:0]   r_decel, n_decel;
    logic          r_cw, n_cw;
    logic          r_moving, n_moving;
    logic [15:0]   r_speed, n_speed;
    logic [15:0]   r_target, n_target;
    logic [9:0]    r_delta, n_delta;
    logic [2:0]    r_phase, n_phase;
    logic [3:0]    r_coils, n_coils;
    logic [15:0]   r_last, n_last;
    logic          r_finished, n_finished;
    logic          r_out_valid;
    srctl_pkg::t_res_payload r_res;

    // divider
    logic [NW-1:0] w_dividend;
    logic [DW-1:0] w_divisor;
    logic          w_div_done;
    logic [NW-1:0] w_quot;

    logic [45:0]   w_ts_prod;
    logic [18:0]   w_ts_q;
    logic [32:0]   w_ramp_prod;
    logic [9:0]    w_ramp_q;
    logic [31:0]   w_raw;
    logic [31:0]   w_mag;
    logic          w_positive;
    logic [32:0]   w_steps33;
    logic [32:0]   w_sum;
    logic [32:0]   w_thr;
    logic [31:0]   w_steps32;
    logic [15:0]   w_steps_half;
    logic [15:0]   w_start16;
    logic [15:0]   w_delta16;
    logic [16:0]   w_up;
    logic [CW-1:0] w_steps_dec;
    logic [2:0]    w_phase_next;

    srctl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // target speed = rpm * steps_per_rev / 60, ramp step = accel / 100
    assign w_ts_prod    = 46'(r_prod[23:2]) * 46'(srctl_pkg::TS_RECIP);
    assign w_ts_q       = w_ts_prod[45:27];
    assign w_ramp_prod  = 33'(r_in.accel_rate) * 33'(srctl_pkg::RAMP_RECIP);
    assign w_ramp_q     = w_ramp_prod[32:23];

    assign w_raw        = r_in.move_steps;
    assign w_mag        = w_raw[31] ? (~w_raw + 32'd1) : w_raw;
    assign w_positive   = (w_raw != '0) && !w_raw[31];
    assign w_steps33    = 33'(r_steps);
    assign w_sum        = w_steps33 + 33'(w_mag);
    assign w_thr        = 33'(w_mag) + 33'(r_decel);
    assign w_steps32    = 32'(r_steps);
    assign w_steps_half = w_steps32[16:1];
    assign w_start16    = 16'(r_start_speed);
    assign w_delta16    = 16'(r_delta);
    assign w_up         = 17'(r_speed) + 17'(w_delta16);
    assign w_steps_dec  = (r_steps != '0) ? (r_steps - CW'(1)) : r_steps;
    assign w_phase_next = r_cw ? (r_phase + 3'd1) : (r_phase - 3'd1);

    always_comb begin
        unique case (i_ctl.div_sel)
            srctl_pkg::DIV_DECEL: begin
                w_dividend = (r_target > w_start16) ? NW'(r_target - w_start16) : '0;
                w_divisor  = w_delta16;
            end
            default: begin
                w_dividend = r_tick;
                w_divisor  = r_speed;
            end
        endcase
    end

    always_comb begin
        n_in       = r_in;
        n_prod     = r_prod;
        n_steps    = r_steps;
        n_decel    = r_decel;
        n_cw       = r_cw;
        n_moving   = r_moving;
        n_speed    = r_speed;
        n_target   = r_target;
        n_delta    = r_delta;
        n_phase    = r_phase;
        n_coils    = r_coils;
        n_last     = r_last;
        n_finished = r_finished;

        if (i_ctl.load_in) begin
            n_in       = i_payload;
            n_prod     = 24'(i_payload.target_rpm) * 24'(r_spr);
            n_finished = 1'b0;
        end

        if (i_ctl.stop_do) begin
            n_moving = 1'b0;
            n_steps  = '0;
            n_coils  = '0;
        end

        if (i_ctl.rate_upd) begin
            n_target = (w_ts_q > 19'(srctl_pkg::MAX16)) ? srctl_pkg::MAX16 : w_ts_q[15:0];
            n_delta  = (w_ramp_q == '0) ? 10'd1 : w_ramp_q;
        end

        if (i_ctl.move_cnt) begin
            if (r_moving) begin
                if (w_positive == r_cw) begin
                    n_steps = (w_sum > 33'(CMAX)) ? CMAX : w_sum[CW-1:0];
                end else if (w_steps33 > w_thr) begin
                    n_steps = r_steps - w_mag[CW-1:0];
                end
            end else begin
                n_steps = (33'(w_mag) > 33'(CMAX)) ? CMAX : w_mag[CW-1:0];
            end
        end

        if (i_ctl.move_begin) begin
            n_cw     = w_positive;
            n_moving = 1'b1;
            n_speed  = w_start16;
        end

        if (i_ctl.step_upd) begin
            n_phase = w_phase_next;
            n_coils = srctl_pkg::phase_coils(w_phase_next);
            n_steps = w_steps_dec;
            if (r_speed < r_target) begin
                n_speed = (w_up > 17'(r_target)) ? r_target : w_up[15:0];
            end else if (r_speed > r_target) begin
                if (r_speed > w_start16 && r_speed > w_delta16) begin
                    n_speed = r_speed - w_delta16;
                end else begin
                    n_speed = w_start16;
                end
            end
            // deceleration begins once the count reaches the threshold
            if (33'(w_steps_dec) == 33'(r_decel)) begin
                n_target = w_start16;
            end
            if (w_steps_dec == '0) begin
                n_moving   = 1'b0;
                n_coils    = '0;
                n_finished = 1'b1;
            end
        end

        if (i_ctl.div_store) begin
            unique case (i_ctl.div_sel)
                srctl_pkg::DIV_DECEL: begin
                    n_decel = (w_steps33 > 33'(r_target)) ? w_quot[15:0] : w_steps_half;
                end
                default: begin
                    if (w_quot == '0) begin
                        n_last = 16'd1;
                    end else if (w_quot > NW'(srctl_pkg::MAX16)) begin
                        n_last = srctl_pkg::MAX16;
                    end else begin
                        n_last = w_quot[15:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_speed <= srctl_pkg::START_SPEED_RST;
            r_spr         <= srctl_pkg::STEPS_PER_REV_RST;
            r_tick        <= srctl_pkg::TICK_RATE_RST;
            r_steps       <= '0;
            r_decel       <= '0;
            r_cw          <= 1'b0;
            r_moving      <= 1'b0;
            r_speed       <= '0;
            r_target      <= '0;
            r_delta       <= 10'd1;
            r_phase       <= '0;
            r_coils       <= '0;
            r_last        <= '0;
            r_finished    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    srctl_pkg::CFG_START_SPEED:   r_start_speed <= i_cfg_data[9:0];
                    srctl_pkg::CFG_STEPS_PER_REV: r_spr         <= i_cfg_data[15:0];
                    srctl_pkg::CFG_TICK_RATE:     r_tick        <= i_cfg_data;
                    default: ;
                endcase
            end
            r_steps    <= n_steps;
            r_decel    <= n_decel;
            r_cw       <= n_cw;
            r_moving   <= n_moving;
            r_speed    <= n_speed;
            r_target   <= n_target;
            r_delta    <= n_delta;
            r_phase    <= n_phase;
            r_coils    <= n_coils;
            r_last     <= n_last;
            r_finished <= n_finished;
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_in   <= n_in;
        r_prod <= n_prod;
        if (i_ctl.out_load) begin
            r_res.coils      <= r_coils;
            // no interval computed yet since reset
            r_res.interval   <= (r_last == '0) ? srctl_pkg::MAX16 : r_last;
            r_res.busy_res   <= r_moving;
            r_res.steps_left <= 32'(r_steps);
            r_res.finished   <= r_finished;
        end
    end

    assign o_stat.func      = r_in.func;
    assign o_stat.moving    = r_moving;
    assign o_stat.move_zero = (w_raw == '0);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_free  = !r_out_valid || i_res_ready;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;
endmodule

/* src/srctl_ctrl.sv */
// ----------------------------------------------------------------------------
// srctl_ctrl: command sequencer
// Decodes each word and steps the datapath through its divider passes.
// ----------------------------------------------------------------------------
module srctl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  srctl_pkg::t_dp_stat  i_stat,
    output srctl_pkg::t_dp_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_MOVE_CNT = 3'd4;
    localparam logic [2:0] S_LAUNCH   = 3'd5;
    localparam logic [2:0] S_STEP     = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_div_sel, n_div_sel;
    logic       r_launch, n_launch;

    always_comb begin
        n_state    = r_state;
        n_div_sel  = r_div_sel;
        n_launch   = r_launch;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.func)
                    srctl_pkg::FUNC_MOVE: begin
                        o_cmd.rate_upd = 1'b1;
                        // a zero step count only updates the ramp and target
                        n_state = i_stat.move_zero ? S_FIN : S_MOVE_CNT;
                    end
                    srctl_pkg::FUNC_STOP: begin
                        o_cmd.stop_do = 1'b1;
                        n_state       = S_FIN;
                    end
                    srctl_pkg::FUNC_STEP: begin
                        n_state = i_stat.moving ? S_STEP : S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = r_div_sel;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                o_cmd.div_sel = r_div_sel;
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    unique case (r_div_sel)
                        srctl_pkg::DIV_DECEL: begin
                            n_state = r_launch ? S_LAUNCH : S_FIN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_MOVE_CNT: begin
                o_cmd.move_cnt = 1'b1;
                n_launch       = !i_stat.moving;
                n_div_sel      = srctl_pkg::DIV_DECEL;
                n_state        = S_DIV_GO;
            end
            S_LAUNCH: begin
                o_cmd.move_begin = 1'b1;
                n_div_sel        = srctl_pkg::DIV_INTV;
                n_state          = S_DIV_GO;
            end
            S_STEP: begin
                o_cmd.step_upd = 1'b1;
                n_div_sel      = srctl_pkg::DIV_INTV;
                n_state        = S_DIV_GO;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_sel <= srctl_pkg::DIV_DECEL;
            r_launch  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
            r_launch  <= n_launch;
        end
    end
endmodule

/* verif/stepper_ramp_controller_tb.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_controller_tb: self-checking bench for the stepper ramp block
// Drives move, stop and step-event words through random valid/ready gaps,
// predicts every status word from a local model of the ramp and phase logic,
// and compares each returned word field by field over several register sets.
// ----------------------------------------------------------------------------
module stepper_ramp_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned N_PHASES     = 5;
    localparam int unsigned PHASE_WORDS  = 190;
    // half-step coil sequence, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_SEQ = {4'h9, 4'h1, 4'h3, 4'h2,
                                             4'h6, 4'h4, 4'hC, 4'h8};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                             cfg_we;
    logic [srctl_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [srctl_pkg::CFG_DATA_W-1:0] cfg_data;

    srctl_stream_if #(.t_payload(srctl_pkg::t_cmd_payload)) cmd_if ();
    srctl_stream_if #(.t_payload(srctl_pkg::t_res_payload)) res_if ();

    stepper_ramp_controller u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register copies
    logic [9:0]  cfg_start = srctl_pkg::START_SPEED_RST;
    logic [15:0] cfg_spr   = srctl_pkg::STEPS_PER_REV_RST;
    logic [23:0] cfg_tick  = srctl_pkg::TICK_RATE_RST;

    // motion state of the local model
    logic [31:0] cnt_left  = '0;
    logic [15:0] decel_at  = '0;
    logic        dir_cw    = 1'b0;
    logic        in_motion = 1'b0;
    logic [15:0] cur_speed = '0;
    logic [15:0] tgt_speed = '0;
    logic [15:0] ramp_q    = '0;
    logic [2:0]  phase_q   = '0;
    logic [3:0]  coil_q    = '0;
    logic [15:0] intv_q    = '0;

    srctl_pkg::t_cmd_payload cmd_word_q[$];
    srctl_pkg::t_res_payload status_pred_q[$];

    int unsigned n_built = 0;
    int unsigned n_err = 0;
    int unsigned n_moves = 0, n_stops = 0, n_steps = 0, n_other = 0, n_done = 0;
    int unsigned n_status = 0;
    int unsigned drv_gap = 0, mon_stall = 0, idle_cycles = 0;
    logic        drv_quiet = 1'b0, mon_quiet = 1'b0;

    function automatic logic [15:0] ticks_for(input logic [15:0] speed);
        logic [23:0] q;
        if (speed == 16'd0) return srctl_pkg::MAX16;
        q = cfg_tick / speed;
        if (q == 24'd0) q = 24'd1;
        if (q > srctl_pkg::MAX16) q = srctl_pkg::MAX16;
        return q[15:0];
    endfunction

    task automatic ramp_predict(input srctl_pkg::t_cmd_payload c,
                                output srctl_pkg::t_res_payload r);
        logic [31:0] raw;
        logic        fwd;
        logic [32:0] mag;
        logic [33:0] sum;
        logic [23:0] ts;
        logic [15:0] div;
        logic [15:0] delta;
        logic [16:0] up;
        logic        done;
        done = 1'b0;
        case (c.func)
            srctl_pkg::FUNC_MOVE: begin
                raw = c.move_steps;
                fwd = (raw != 32'd0) && !raw[31];
                mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
                ramp_q = c.accel_rate;
                ts = (24'(c.target_rpm) * 24'(cfg_spr)) / 24'(srctl_pkg::SECS_PER_MIN);
                tgt_speed = (ts > srctl_pkg::MAX16) ? srctl_pkg::MAX16 : ts[15:0];
                if (raw != 32'd0) begin
                    if (in_motion) begin
                        if (fwd == dir_cw) begin
                            sum = {2'b00, cnt_left} + {1'b0, mag};
                            cnt_left = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                        end else if ({1'b0, cnt_left} > mag + decel_at) begin
                            // opposite direction only trims what lies before the ramp-down
                            cnt_left = cnt_left - mag[31:0];
                        end
                    end else begin
                        cnt_left = mag[31:0];
                    end
                    if (cnt_left > tgt_speed) begin
                        div = (ramp_q >= srctl_pkg::RAMP_DIV) ?
                              ramp_q / srctl_pkg::RAMP_DIV : 16'd1;
                        decel_at = (tgt_speed > 16'(cfg_start))
                                   ? (tgt_speed - 16'(cfg_start)) / div : 16'd0;
                    end else begin
                        decel_at = cnt_left[16:1];
                    end
                    if (!in_motion) begin
                        dir_cw = fwd;
                        in_motion = 1'b1;
                        cur_speed = 16'(cfg_start);
                        intv_q = ticks_for(cur_speed);
                    end
                end
            end
            srctl_pkg::FUNC_STOP: begin
                in_motion = 1'b0;
                cnt_left = '0;
                coil_q = '0;
            end
            srctl_pkg::FUNC_STEP: begin
                if (in_motion) begin
                    phase_q = dir_cw ? phase_q + 3'd1 : phase_q - 3'd1;
                    coil_q = HALF_STEP_SEQ[phase_q*4 +: 4];
                    if (cnt_left != 32'd0) cnt_left = cnt_left - 32'd1;
                    delta = ramp_q / srctl_pkg::RAMP_DIV;
                    if (delta == 16'd0) delta = 16'd1;
                    if (cur_speed < tgt_speed) begin
                        up = cur_speed + delta;
                        cur_speed = (up > tgt_speed) ? tgt_speed : up[15:0];
                    end else if (cur_speed > tgt_speed) begin
                        if (cur_speed > 16'(cfg_start) && cur_speed > delta)
                            cur_speed = cur_speed - delta;
                        else
                            cur_speed = 16'(cfg_start);
                    end
                    if (cnt_left == 32'(decel_at)) tgt_speed = 16'(cfg_start);
                    intv_q = ticks_for(cur_speed);
                    if (cnt_left == 32'd0) begin
                        in_motion = 1'b0;
                        coil_q = '0;
                        done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.coils      = coil_q;
        r.interval   = (intv_q == 16'd0) ? srctl_pkg::MAX16 : intv_q;
        r.busy_res   = in_motion;
        r.steps_left = cnt_left;
        r.finished   = done;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endtask

    // command side: one word from the pending queue at a time
    always @(posedge clk) begin : cmd_driver
        srctl_pkg::t_res_payload pred;
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                ramp_predict(cmd_if.payload, pred);
                status_pred_q.push_back(pred);
                case (cmd_if.payload.func)
                    srctl_pkg::FUNC_MOVE: n_moves++;
                    srctl_pkg::FUNC_STOP: n_stops++;
                    srctl_pkg::FUNC_STEP: n_steps++;
                    default:              n_other++;
                endcase
                if (pred.finished) n_done++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (drv_gap != 0) begin
                    drv_gap <= drv_gap - 1;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_word_q.size() != 0) begin
                    cmd_if.payload <= cmd_word_q.pop_front();
                    cmd_if.valid <= 1'b1;
                    drv_gap <= drv_quiet ? 0 : $urandom_range(0, 9);
                    if ($urandom_range(0, 39) == 0) drv_quiet <= !drv_quiet;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // status side: check each word, then maybe hold off ready
    always @(posedge clk) begin : res_monitor
        srctl_pkg::t_res_payload want;
        int unsigned             hold;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            mon_stall <= 0;
        end else begin
            hold = mon_stall;
            if (res_if.valid && res_if.ready) begin
                n_status++;
                if (status_pred_q.size() == 0) begin
                    $error("status word with no command outstanding");
                    n_err++;
                end else begin
                    want = status_pred_q.pop_front();
                    cmp_field("coils", 32'(want.coils), 32'(res_if.payload.coils));
                    cmp_field("interval", 32'(want.interval),
                              32'(res_if.payload.interval));
                    cmp_field("busy_res", 32'(want.busy_res),
                              32'(res_if.payload.busy_res));
                    cmp_field("steps_left", want.steps_left, res_if.payload.steps_left);
                    cmp_field("finished", 32'(want.finished),
                              32'(res_if.payload.finished));
                end
                hold = mon_quiet ? 0 : $urandom_range(0, 9);
                if ($urandom_range(0, 39) == 0) mon_quiet <= !mon_quiet;
            end
            if (hold != 0) begin
                res_if.ready <= 1'b0;
                mon_stall <= hold - 1;
            end else begin
                res_if.ready <= 1'b1;
                mon_stall <= 0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [srctl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srctl_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            srctl_pkg::CFG_START_SPEED:   cfg_start = val[9:0];
            srctl_pkg::CFG_STEPS_PER_REV: cfg_spr = val[15:0];
            srctl_pkg::CFG_TICK_RATE:     cfg_tick = val;
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [1:0] f, input logic [31:0] s,
                             input logic [7:0] rpm, input logic [15:0] acc);
        srctl_pkg::t_cmd_payload c;
        c.func       = f;
        c.move_steps = s;
        c.target_rpm = rpm;
        c.accel_rate = acc;
        cmd_word_q.push_back(c);
        n_built++;
    endtask

    task automatic settle();
        while (cmd_word_q.size() != 0 || cmd_if.valid || status_pred_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic gen_random(input int unsigned n);
        int unsigned stop_at, kind, len, k;
        logic [31:0] mag;
        logic [7:0]  rpm;
        logic [15:0] acc;
        logic [1:0]  f;
        stop_at = n_built + n;
        while (n_built < stop_at) begin
            kind = $urandom_range(0, 99);
            rpm = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0:       acc = 16'($urandom_range(0, 99));
                1:       acc = 16'($urandom_range(100, 3000));
                default: acc = 16'($urandom_range(0, 65535));
            endcase
            mag = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(1, 40);
            if (kind < 75) begin
                // full move: one word per step of its count and up to two more, mostly step
                // events, with the odd retarget or extra count while it is running
                queue_cmd(srctl_pkg::FUNC_MOVE, $urandom_range(0, 1) ? -mag : mag,
                          rpm, acc);
                len = mag + $urandom_range(0, 2);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 39))
                        0: queue_cmd(srctl_pkg::FUNC_MOVE,
                                     $urandom_range(0, 1) ? -$urandom_range(1, 20)
                                                          : $urandom_range(1, 20),
                                     8'($urandom), 16'($urandom));
                        1: queue_cmd(srctl_pkg::FUNC_MOVE, 32'd0,
                                     8'($urandom), 16'($urandom));
                        default: queue_cmd(srctl_pkg::FUNC_STEP, $urandom,
                                           8'($urandom), 16'($urandom));
                    endcase
                end
            end else if (kind < 90) begin
                f = 2'($urandom_range(0, 3));
                queue_cmd(f, $urandom, 8'($urandom), 16'($urandom));
                // a full-range count would never run out
                if (f == srctl_pkg::FUNC_MOVE)
                    queue_cmd(srctl_pkg::FUNC_STOP, $urandom, 8'($urandom), 16'($urandom));
            end else begin
                queue_cmd(srctl_pkg::FUNC_MOVE, $urandom_range(0, 1) ? -mag : mag,
                          rpm, acc);
                repeat ($urandom_range(0, mag)) queue_cmd(srctl_pkg::FUNC_STEP, '0, '0, '0);
                queue_cmd(srctl_pkg::FUNC_STOP, '0, '0, '0);
            end
        end
    endtask

    initial begin
        int unsigned p;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // nothing computed yet: interval must read all ones
        queue_cmd(srctl_pkg::FUNC_STEP, '0, '0, '0);
        queue_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_STOP, '0, '0, '0);
        // zero count only retargets
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'd0, 8'd255, 16'hFFFF);
        // count saturation on repeated same-direction moves
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'h7FFF_FFFF, 8'd255, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'h7FFF_FFFF, 8'd255, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'h7FFF_FFFF, 8'd1, 16'hFFFF);
        // big ramp step overshoots the low target and gets clamped
        queue_cmd(srctl_pkg::FUNC_STEP, '0, '0, '0);
        // opposite direction: trimmed twice, then refused
        queue_cmd(srctl_pkg::FUNC_MOVE, -32'sd5, 8'd1, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'h8000_0000, 8'd1, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'h8000_0001, 8'd1, 16'hFFFF);
        queue_cmd(srctl_pkg::FUNC_STOP, '0, '0, '0);
        // target under start speed, counterclockwise, run past the end
        queue_cmd(srctl_pkg::FUNC_MOVE, -32'sd3, 8'd0, 16'd0);
        repeat (4) queue_cmd(srctl_pkg::FUNC_STEP, '0, '0, '0);
        // short move whose ramp-down point is half the count
        queue_cmd(srctl_pkg::FUNC_MOVE, 32'd6, 8'd1, 16'd250);
        repeat (6) queue_cmd(srctl_pkg::FUNC_STEP, '0, '0, '0);
        settle();

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(srctl_pkg::CFG_START_SPEED, 24'd1000);
                    write_reg(srctl_pkg::CFG_STEPS_PER_REV, 24'd65535);
                    write_reg(srctl_pkg::CFG_TICK_RATE, 24'd16000000);
                end
                1: begin
                    write_reg(srctl_pkg::CFG_START_SPEED, 24'd1);
                    write_reg(srctl_pkg::CFG_STEPS_PER_REV, 24'd1);
                    write_reg(srctl_pkg::CFG_TICK_RATE, 24'd1);
                end
                default: begin
                    write_reg(srctl_pkg::CFG_START_SPEED, 24'($urandom_range(1, 1000)));
                    write_reg(srctl_pkg::CFG_STEPS_PER_REV,
                              $urandom_range(0, 1) ? 24'($urandom_range(1, 600))
                                                   : 24'($urandom_range(1, 65535)));
                    write_reg(srctl_pkg::CFG_TICK_RATE, 24'($urandom_range(1, 16000000)));
                end
            endcase
            gen_random(PHASE_WORDS);
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d command words (%0d moves, %0d stops, %0d step events, %0d unused)",
                 n_moves + n_stops + n_steps + n_other, n_moves, n_stops, n_steps, n_other);
        $display("%0d status words checked over %0d register sets, %0d motions run out, %0d errors",
                 n_status, N_PHASES + 1, n_done, n_err);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
